// ----- src/complex_vector_normalize_defines.svh -----
`ifndef COMPLEX_VECTOR_NORMALIZE_DEFINES_SVH
`define COMPLEX_VECTOR_NORMALIZE_DEFINES_SVH

// Clocked assertion with asynchronous active-low reset.
`define CVN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define CVN_ASSERT_CLK(lbl, prop, msg) \
  `CVN_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- src/cvn_pkg.sv -----
package cvn_pkg;

  localparam int VECTOR_LEN = 16;
  localparam int DATA_W     = 16;
  localparam int CNT_W      = $clog2(VECTOR_LEN + 1);
  localparam int IDX_W      = $clog2(VECTOR_LEN);
  localparam int SUM_W      = 38;
  localparam int RAD_W      = SUM_W + 16;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int NORM_W     = 20;
  localparam int Q_W        = 30;
  localparam int N_W        = 40;
  localparam int DSH_W      = ROOT_W + 1 + Q_W - 1;
  localparam int SQ_STEPS   = ROOT_W;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_FLUSH,
    S_ROOT,
    S_SQRT,
    S_READ,
    S_DIVST,
    S_DIV,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic acc_clr;
    logic sqrt_start;
    logic rd_en;
    logic div_start;
    logic out_load;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ----- src/cvn_div.sv -----
module cvn_div import cvn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] part_i,
  input  logic [ROOT_W-1:0]        root_i,
  output logic                     done_o,
  output logic [DATA_W-1:0]        res_o
);

  logic [4:0]       cnt_q;
  logic             neg_q;
  logic [N_W-1:0]   rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [Q_W-1:0]   quo_q;
  logic [DATA_W-1:0] mag;
  logic [DSH_W-1:0] rem_ext;
  logic [DATA_W:0]  qc;

  assign mag     = part_i[DATA_W-1] ? DATA_W'(-part_i) : DATA_W'(part_i);
  assign rem_ext = DSH_W'(rem_q);
  assign done_o  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 5'(Q_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // (mag * 2^23 + R) / (2R), one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= part_i[DATA_W-1];
      rem_q <= N_W'({mag, 23'b0}) + N_W'(root_i);
      dsh_q <= DSH_W'({root_i, 1'b0}) << (Q_W - 1);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (rem_ext >= dsh_q) begin
        rem_q <= N_W'(rem_ext - dsh_q);
        quo_q <= {quo_q[Q_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[Q_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  always_comb begin
    if (neg_q) begin
      qc    = (quo_q > Q_W'(32768)) ? 17'd32768 : 17'(quo_q);
      res_o = DATA_W'(17'd0 - qc);
    end else begin
      qc    = (quo_q > Q_W'(32767)) ? 17'd32767 : 17'(quo_q);
      res_o = DATA_W'(qc);
    end
  end

endmodule

// ----- src/cvn_ctrl.sv -----
module cvn_ctrl import cvn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_acc_i,
  input  logic last_elem_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_COLLECT: begin
        in_stall_o = 1'b0;
        if (in_acc_i && last_elem_i) state_d = S_FLUSH;
      end
      // last square lands in the sum here
      S_FLUSH: state_d = S_ROOT;
      S_ROOT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT;
      end
      S_SQRT: if (sts_i.sqrt_done) state_d = S_READ;
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DIVST;
      end
      S_DIVST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: if (sts_i.div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.acc_clr = 1'b1;
            state_d       = S_COLLECT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: state_d = S_COLLECT;
    endcase
  end

endmodule

// ----- src/cvn_dp.sv -----
module cvn_dp import cvn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_acc_i,
  input  logic signed [DATA_W-1:0] elem_re_i,
  input  logic signed [DATA_W-1:0] elem_im_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] out_re_o,
  output logic signed [DATA_W-1:0] out_im_o,
  output logic [NORM_W-1:0]        norm_value_o,
  output logic                     zero_norm_o,
  output logic                     overflow_flag_o,
  output logic                     last_out_o
);

  logic [2*DATA_W-1:0] store_q [VECTOR_LEN];
  logic [2*DATA_W-1:0] rd_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    idx_q;
  logic                drop_q;
  logic [31:0]         sq_q;
  logic                sq_vld_q;
  logic [SUM_W-1:0]    sum_q;
  logic [RAD_W-1:0]    rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [4:0]          sq_cnt_q;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic signed [31:0]  re2, im2;
  logic                div_re_done, div_im_done;
  logic [DATA_W-1:0]   div_re, div_im;
  logic                out_valid_q;
  logic                zero;

  assign re2    = elem_re_i * elem_re_i;
  assign im2    = elem_im_i * elem_im_i;
  assign zero   = (sum_q == '0);
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  assign sts_o.sqrt_done = (sq_cnt_q == '0);
  assign sts_o.div_done  = div_re_done && div_im_done;
  assign sts_o.emit_last = (CNT_W'(idx_q) + CNT_W'(1) == cnt_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      sq_vld_q <= 1'b0;
      sum_q    <= '0;
      idx_q    <= '0;
      sq_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sq_vld_q <= 1'b0;
      if (in_acc_i) begin
        if (cnt_q != CNT_W'(VECTOR_LEN)) begin
          cnt_q    <= cnt_q + CNT_W'(1);
          sq_vld_q <= 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (sq_vld_q) sum_q <= sum_q + SUM_W'(sq_q);
      if (cmd_i.sqrt_start) begin
        sq_cnt_q <= 5'(SQ_STEPS);
      end else if (sq_cnt_q != '0) begin
        sq_cnt_q <= sq_cnt_q - 5'd1;
      end
      if (cmd_i.idx_inc) idx_q <= idx_q + IDX_W'(1);
      if (cmd_i.acc_clr) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
        sum_q  <= '0;
        idx_q  <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && cnt_q != CNT_W'(VECTOR_LEN)) begin
      store_q[cnt_q[IDX_W-1:0]] <= {elem_re_i, elem_im_i};
      sq_q <= 32'(re2) + 32'(im2);
    end
    if (cmd_i.rd_en) rd_q <= store_q[idx_q];
  end

  // restoring square root of sum * 2^16, one root bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= {sum_q, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (sq_cnt_q != '0) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  cvn_div u_div_re (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .part_i  (rd_q[2*DATA_W-1:DATA_W]),
    .root_i  (root_q),
    .done_o  (div_re_done),
    .res_o   (div_re)
  );

  cvn_div u_div_im (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .part_i  (rd_q[DATA_W-1:0]),
    .root_i  (root_q),
    .done_o  (div_im_done),
    .res_o   (div_im)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_o        <= zero ? '0 : div_re;
      out_im_o        <= zero ? '0 : div_im;
      norm_value_o    <= NORM_W'(root_q >> 8);
      zero_norm_o     <= zero;
      overflow_flag_o <= drop_q;
      last_out_o      <= sts_o.emit_last;
    end
  end

endmodule

// ----- src/complex_vector_normalize.sv -----
// Complex vector normaliser.
// Input channel (in_valid_i / in_stall_o): one complex element per request,
// Q4.12 real and imaginary parts, last_elem_i on the final one. Elements are
// taken one per cycle while collecting; up to 16 are stored, further ones are
// dropped and flagged.
// After the last element the input stalls. The final square reaches the sum,
// the square root is started, then the bit-serial square root computes its
// 27 root bits.
// Each stored element then goes through a store read, a divider start, the
// two bit-serial dividers (30 quotient bits, real and imaginary in parallel)
// and, once the output register is free, a load into the output register.
// Output channel (out_valid_o / out_stall_i): one normalised element per
// request in Q1.14 with the norm and flags; last_out_o marks the final one.
// A stall holds the output register and the sequencer waits before loading
// the next result. Input is taken again after the last result is loaded.
// Reset clears the sum, count and drop flag; the element store is not cleared.
module complex_vector_normalize import cvn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] elem_re_i,
  input  logic signed [DATA_W-1:0] elem_im_i,
  input  logic                     last_elem_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] out_re_o,
  output logic signed [DATA_W-1:0] out_im_o,
  output logic [NORM_W-1:0]        norm_value_o,
  output logic                     zero_norm_o,
  output logic                     overflow_flag_o,
  output logic                     last_out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  cvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .last_elem_i (last_elem_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  cvn_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_acc_i        (in_acc),
    .elem_re_i       (elem_re_i),
    .elem_im_i       (elem_im_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_re_o        (out_re_o),
    .out_im_o        (out_im_o),
    .norm_value_o    (norm_value_o),
    .zero_norm_o     (zero_norm_o),
    .overflow_flag_o (overflow_flag_o),
    .last_out_o      (last_out_o)
  );

endmodule

// ----- src/cvn_checker.sv -----
`include "complex_vector_normalize_defines.svh"

module cvn_checker import cvn_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic signed [DATA_W-1:0] elem_re_i,
  input logic signed [DATA_W-1:0] elem_im_i,
  input logic                     last_elem_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] out_re_o,
  input logic signed [DATA_W-1:0] out_im_o,
  input logic [NORM_W-1:0]        norm_value_o,
  input logic                     zero_norm_o,
  input logic                     overflow_flag_o,
  input logic                     last_out_o
);

  `CVN_ASSERT_CLK(a_stall_after_last, in_valid_i && !in_stall_o && last_elem_i |=> in_stall_o, "input taken after last element")
  `CVN_ASSERT_CLK(a_zero_outputs, out_valid_o && zero_norm_o |-> out_re_o == '0 && out_im_o == '0, "zero vector gave nonzero output")
  `CVN_ASSERT_CLK(a_zero_norm_flag, out_valid_o && zero_norm_o |-> norm_value_o == '0, "zero flag with nonzero norm")
  `CVN_ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled request dropped")

endmodule

bind complex_vector_normalize cvn_checker u_cvn_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
  import cvn_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } element_t;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [NORM_W-1:0]        norm;
    logic                     zero;
    logic                     dropped;
    logic                     last;
  } unit_elem_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DATA_W-1:0] elem_re_i = '0;
  logic signed [DATA_W-1:0] elem_im_i = '0;
  logic last_elem_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] out_re_o, out_im_o;
  logic [NORM_W-1:0] norm_value_o;
  logic zero_norm_o, overflow_flag_o, last_out_o;

  complex_vector_normalize DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  element_t   pending_q[$];
  unit_elem_t unit_q[$];
  int errors = 0;

  // predictor state
  logic [31:0] held_elems[VECTOR_LEN];
  logic [SUM_W-1:0] energy = '0;
  int held_cnt = 0;
  bit lost = 1'b0;

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] scaled(logic signed [DATA_W-1:0] x,
                                                logic [63:0] root);
    logic [63:0] mag, q;
    mag = (x < 0) ? 64'(-int'(x)) : 64'(int'(x));
    q = ((mag << 23) + root) / (2 * root);
    if (x < 0) begin
      if (q > 32768) q = 32768;
      return DATA_W'(-q);
    end
    if (q > 32767) q = 32767;
    return DATA_W'(q);
  endfunction

  task automatic predict(element_t e);
    logic [63:0] root;
    logic signed [31:0] pr, pi;
    unit_elem_t u;
    bit zero;
    if (held_cnt < VECTOR_LEN) begin
      held_elems[held_cnt] = {e.re, e.im};
      pr = e.re * e.re;
      pi = e.im * e.im;
      energy = energy + SUM_W'(pr) + SUM_W'(pi);
      held_cnt++;
    end else begin
      lost = 1'b1;
    end
    if (!e.last) return;
    root = int_root(64'(energy) << 16);
    zero = (energy == 0);
    for (int k = 0; k < held_cnt; k++) begin
      u.re = zero ? '0 : scaled(held_elems[k][31:16], root);
      u.im = zero ? '0 : scaled(held_elems[k][15:0], root);
      u.norm = NORM_W'(root >> 8);
      u.zero = zero;
      u.dropped = lost;
      u.last = (k + 1 == held_cnt);
      unit_q.push_back(u);
    end
    energy = '0;
    held_cnt = 0;
    lost = 1'b0;
  endtask

  // driver: bursts and gaps
  int burst = 0, gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict('{elem_re_i, elem_im_i, last_elem_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          element_t e;
          e = pending_q.pop_front();
          elem_re_i <= e.re;
          elem_im_i <= e.im;
          last_elem_i <= e.last;
          in_valid_i <= 1'b1;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(0, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode = 0, mode_left = 0;
  always @(posedge clk_i) begin
    unit_elem_t u;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected request re=%0d im=%0d", $time, out_re_o, out_im_o);
          errors++;
        end else begin
          u = unit_q.pop_front();
          if (out_re_o !== u.re) begin
            $display("%0t: out_re exp %0d got %0d", $time, u.re, out_re_o);
            errors++;
          end
          if (out_im_o !== u.im) begin
            $display("%0t: out_im exp %0d got %0d", $time, u.im, out_im_o);
            errors++;
          end
          if (norm_value_o !== u.norm) begin
            $display("%0t: norm exp %0d got %0d", $time, u.norm, norm_value_o);
            errors++;
          end
          if (zero_norm_o !== u.zero) begin
            $display("%0t: zero_norm exp %0b got %0b", $time, u.zero, zero_norm_o);
            errors++;
          end
          if (overflow_flag_o !== u.dropped) begin
            $display("%0t: overflow exp %0b got %0b", $time, u.dropped, overflow_flag_o);
            errors++;
          end
          if (last_out_o !== u.last) begin
            $display("%0t: last_out exp %0b got %0b", $time, u.last, last_out_o);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 200);
      end else mode_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return DATA_W'($urandom_range(0, 15)) - 16'sd8;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic add_vector(int len);
    for (int i = 0; i < len; i++)
      pending_q.push_back('{rand_part(), rand_part(), i == len - 1});
  endtask

  initial begin
    int total;
    // extremes, single element
    pending_q.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1});
    pending_q.push_back('{16'sh8000, 16'sh8000, 1'b1});
    pending_q.push_back('{16'sh0001, 16'sh0000, 1'b1});
    pending_q.push_back('{16'sh0000, 16'shFFFF, 1'b1});
    // zero vector
    pending_q.push_back('{16'sh0000, 16'sh0000, 1'b0});
    pending_q.push_back('{16'sh0000, 16'sh0000, 1'b1});
    // tiny against huge
    pending_q.push_back('{16'sh0001, 16'sh8000, 1'b0});
    pending_q.push_back('{16'sh7FFF, 16'sh0001, 1'b1});
    // store full: 18 elements, last two dropped
    add_vector(18);
    total = pending_q.size();
    while (total < 230) begin
      int len;
      case ($urandom_range(0, 9))
        0: len = $urandom_range(17, 20);
        1: len = VECTOR_LEN;
        default: len = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 15) == 0) begin
        for (int i = 0; i < len; i++)
          pending_q.push_back('{16'sh0, 16'sh0, i == len - 1});
      end else add_vector(len);
      total += len;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (unit_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end
endmodule
